// ===== sv/sbmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared sizes, codes and port bundles of the shared-buffer multi-queue unit.
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam int SLOTS  = 16;
    localparam int QUEUES = 4;

    localparam int DW = 32;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int IW = 2;

    localparam logic [LW-1:0] NIL_LINK = LW'(SLOTS);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic          rd_en;
        logic          wr_en;
        logic [AW-1:0] addr;
        logic [LW-1:0] wdata;
    } t_link_req;

    typedef struct packed {
        logic          rd_en;
        logic          wr_en;
        logic [AW-1:0] addr;
        logic [DW-1:0] wdata;
    } t_data_req;

    // Fold a queue number into range; at most three subtract steps on 3 bits.
    function automatic logic [QW-1:0] queue_index(input logic [IW-1:0] id);
        logic [IW:0] t;
        t = {1'b0, id};
        for (int k = 0; k < 3; k++) begin
            if (int'(t) >= QUEUES) begin
                t = t - (IW+1)'(QUEUES);
            end
        end
        return QW'(t);
    endfunction

endpackage

// ===== sv/sbmq_link_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_link_store
// Single-port next-link memory with per-slot valid bits; an unwritten slot
// reads as a link to the following slot.
// ----------------------------------------------------------------------------
module sbmq_link_store
    import sbmq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_link_req     i_req,
    output logic [LW-1:0] o_rdata
);

    logic [LW-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    logic [LW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_vld[i_req.addr] ? r_mem[i_req.addr]
                                         : LW'(i_req.addr) + LW'(1);
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sbmq_data_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_data_store
// Single-port slot data memory with registered read.
// ----------------------------------------------------------------------------
module sbmq_data_store
    import sbmq_pkg::*;
(
    input  logic          i_clk,
    input  t_data_req     i_req,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [SLOTS];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sbmq_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_seq
// Request sequencer: holds queue heads, tails and the free-list head, and
// drives the link and data stores over an access step and an update step.
// ----------------------------------------------------------------------------
module sbmq_seq
    import sbmq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  logic [IW-1:0]        i_queue_id,
    input  logic signed [DW-1:0] i_push_value,
    input  logic [LW-1:0]        i_link_rdata,
    input  logic [DW-1:0]        i_data_rdata,
    output t_link_req            o_link_req,
    output t_data_req            o_data_req,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic signed [DW-1:0] o_pop_value
);

    t_state        r_state, n_state;
    logic [LW-1:0] r_head [QUEUES];
    logic [LW-1:0] n_head [QUEUES];
    logic [LW-1:0] r_tail [QUEUES];
    logic [LW-1:0] n_tail [QUEUES];
    logic [LW-1:0] r_free, n_free;
    logic          r_valid, n_valid;

    logic          r_cmd, n_cmd;
    logic [QW-1:0] r_q, n_q;
    logic [DW-1:0] r_val, n_val;
    logic [LW-1:0] r_slot, n_slot;
    t_status       r_status, n_status;
    t_status       r_out_status, n_out_status;
    logic [DW-1:0] r_out_value, n_out_value;

    logic accept;

    assign busy   = (r_state == ST_ACCESS);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_free  <= '0;
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= NIL_LINK;
                r_tail[i] <= NIL_LINK;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_free  <= n_free;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_q          <= n_q;
        r_val        <= n_val;
        r_slot       <= n_slot;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free       = r_free;
        n_valid      = 1'b0;
        n_cmd        = r_cmd;
        n_q          = r_q;
        n_val        = r_val;
        n_slot       = r_slot;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        o_link_req   = '0;
        o_data_req   = '0;

        unique case (r_state)
            ST_IDLE: begin
                n_state = ST_IDLE;
            end
            ST_ACCESS: begin
                n_state = ST_UPDATE;
                if (r_cmd == CMD_PUSH) begin
                    n_slot = r_free;
                    if (r_free == NIL_LINK) begin
                        n_status = STAT_FULL;
                    end else begin
                        // fetch the next free slot, store the value
                        n_status         = STAT_DONE;
                        o_link_req.rd_en = 1'b1;
                        o_link_req.addr  = r_free[AW-1:0];
                        o_data_req.wr_en = 1'b1;
                        o_data_req.addr  = r_free[AW-1:0];
                        o_data_req.wdata = r_val;
                    end
                end else begin
                    n_slot = r_head[r_q];
                    if (r_head[r_q] == NIL_LINK) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_status         = STAT_DONE;
                        o_link_req.rd_en = 1'b1;
                        o_link_req.addr  = r_head[r_q][AW-1:0];
                        o_data_req.rd_en = 1'b1;
                        o_data_req.addr  = r_head[r_q][AW-1:0];
                    end
                end
            end
            ST_UPDATE: begin
                n_state      = ST_IDLE;
                n_valid      = 1'b1;
                n_out_status = r_status;
                n_out_value  = '0;
                if (r_status == STAT_DONE) begin
                    if (r_cmd == CMD_POP) begin
                        // single entry left: queue goes empty
                        if (r_head[r_q] == r_tail[r_q]) begin
                            n_head[r_q] = NIL_LINK;
                            n_tail[r_q] = NIL_LINK;
                        end else begin
                            n_head[r_q] = i_link_rdata;
                        end
                        o_link_req.wr_en = 1'b1;
                        o_link_req.addr  = r_slot[AW-1:0];
                        o_link_req.wdata = r_free;
                        n_free           = r_slot;
                        n_out_value      = i_data_rdata;
                    end else begin
                        n_free = i_link_rdata;
                        if (r_head[r_q] == NIL_LINK) begin
                            n_head[r_q] = r_slot;
                        end else begin
                            o_link_req.wr_en = 1'b1;
                            o_link_req.addr  = r_tail[r_q][AW-1:0];
                            o_link_req.wdata = r_slot;
                        end
                        n_tail[r_q] = r_slot;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (accept) begin
            n_state = ST_ACCESS;
            n_cmd   = i_command;
            n_q     = queue_index(i_queue_id);
            n_val   = i_push_value;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_out_status;
    assign o_pop_value = r_out_value;

endmodule

// ===== sv/shared_buffer_multi_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_unit
// Several FIFO queues sharing one slot store through next-links and a free
// list.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. Each
// request passes an access and an update step: the single-port link memory
// is read in the first (next free slot or next queue entry) and written in
// the second (tail link of a non-empty queue, or free-list link). busy is
// high only during the access step, so a new request may be taken
// during the update step of the last. The result appears on o_status and
// o_pop_value for exactly one cycle with o_valid high; the receiver cannot
// stall it and must capture it then. Status reports done, push refused with
// the store full, or pop refused with the queue empty; o_pop_value is zero
// except for a successful pop. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_unit
    import sbmq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  logic [IW-1:0]        i_queue_id,
    input  logic signed [DW-1:0] i_push_value,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic signed [DW-1:0] o_pop_value
);

    t_link_req     link_req;
    t_data_req     data_req;
    logic [LW-1:0] link_rdata;
    logic [DW-1:0] data_rdata;

    sbmq_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_queue_id   (i_queue_id),
        .i_push_value (i_push_value),
        .i_link_rdata (link_rdata),
        .i_data_rdata (data_rdata),
        .o_link_req   (link_req),
        .o_data_req   (data_req),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value)
    );

    sbmq_link_store u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (link_req),
        .o_rdata (link_rdata)
    );

    sbmq_data_store u_data (
        .i_clk   (i_clk),
        .i_req   (data_req),
        .o_rdata (data_rdata)
    );

endmodule

// ===== sv/sbmq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_checker
// Port-level timing and result checks for the multi-queue unit.
// ----------------------------------------------------------------------------
module sbmq_checker
    import sbmq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic [1:0]           o_status,
    input logic signed [DW-1:0] o_pop_value
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted request");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result missing three cycles after acceptance");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_DONE)) |-> (o_pop_value == '0))
        else $error("refused request returned a nonzero value");

endmodule

bind shared_buffer_multi_queue_unit sbmq_checker u_sbmq_checker (.*);

// ===== test/sbmq_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_result_checker
// Watches the request and result ports of the multi-queue unit, keeps its own
// copy of the slot store, the links, the queue ends and the free list, and
// compares every result with the outcome predicted for the oldest request.
// ----------------------------------------------------------------------------
module sbmq_result_checker
    import sbmq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 i_command,
    input  logic [IW-1:0]        i_queue_id,
    input  logic [DW-1:0]        i_push_value,
    input  logic                 o_valid,
    input  logic [1:0]           o_status,
    input  logic [DW-1:0]        o_pop_value,
    output int                   fail_count,
    output int                   pending,
    output int                   checked,
    output int                   full_hits,
    output int                   empty_hits
);

    typedef struct packed {
        t_status       status;
        logic [DW-1:0] pop_value;
    } t_outcome;

    logic [DW-1:0] data_mem  [SLOTS];
    logic [LW-1:0] link_mem  [SLOTS];
    logic [LW-1:0] head_ptr  [QUEUES];
    logic [LW-1:0] tail_ptr  [QUEUES];
    logic [LW-1:0] free_ptr;

    t_outcome outcome_fifo [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        full_hits  = 0;
        empty_hits = 0;
    end

    function automatic logic is_null(input logic [LW-1:0] p);
        return int'(p) >= SLOTS;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_store();
        for (int i = 0; i < SLOTS; i++) begin
            data_mem[i] = '0;
            link_mem[i] = LW'(i + 1);
        end
        link_mem[SLOTS-1] = NIL_LINK;
        for (int i = 0; i < QUEUES; i++) begin
            head_ptr[i] = NIL_LINK;
            tail_ptr[i] = NIL_LINK;
        end
        free_ptr = '0;
        outcome_fifo.delete();
    endtask

    // Apply one request to the shadow store and return its outcome.
    task automatic apply_queue_op(input logic cmd, input logic [IW-1:0] qid,
                                  input logic [DW-1:0] value, output t_outcome res);
        int            q;
        logic [LW-1:0] slot;
        q = int'(qid) % QUEUES;
        res.status    = STAT_DONE;
        res.pop_value = '0;
        if (cmd == CMD_PUSH) begin
            slot = free_ptr;
            if (is_null(slot)) begin
                res.status = STAT_FULL;
            end else begin
                free_ptr = link_mem[slot];
                if (is_null(head_ptr[q]) || is_null(tail_ptr[q])) begin
                    head_ptr[q] = slot;
                end else begin
                    link_mem[tail_ptr[q]] = slot;
                end
                link_mem[slot] = NIL_LINK;
                tail_ptr[q]    = slot;
                data_mem[slot] = value;
            end
        end else begin
            slot = head_ptr[q];
            if (is_null(slot)) begin
                res.status = STAT_EMPTY;
            end else begin
                head_ptr[q] = link_mem[slot];
                // drop the tail too once the queue runs dry
                if (is_null(head_ptr[q])) begin
                    head_ptr[q] = NIL_LINK;
                    tail_ptr[q] = NIL_LINK;
                end
                link_mem[slot] = free_ptr;
                free_ptr       = slot;
                res.pop_value  = data_mem[slot];
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome predicted;
        t_outcome oldest;
        if (!i_rst_n) begin
            clear_store();
        end else begin
            if (start && !busy) begin
                apply_queue_op(i_command, i_queue_id, i_push_value, predicted);
                if (predicted.status == STAT_FULL) full_hits++;
                if (predicted.status == STAT_EMPTY) empty_hits++;
                outcome_fifo.push_back(predicted);
            end
            if (o_valid) begin
                if (outcome_fifo.size() == 0) begin
                    report_mismatch($sformatf("result with no request waiting: status %0d",
                                              o_status));
                end else begin
                    oldest = outcome_fifo.pop_front();
                    checked++;
                    if (o_status !== oldest.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, oldest.status));
                    end
                    if (o_pop_value !== oldest.pop_value) begin
                        report_mismatch($sformatf("pop value %h, expected %h",
                                                  o_pop_value, oldest.pop_value));
                    end
                end
            end
        end
        pending <= outcome_fifo.size();
    end

endmodule

// ===== test/tb_shared_buffer_multi_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_buffer_multi_queue_unit
// Drives push and pop requests into the multi-queue unit: a directed opening
// that fills the store, overflows it and drains a queue, then biased random
// traffic under three sender idle profiles. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_shared_buffer_multi_queue_unit;
    import sbmq_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_command;
    logic [IW-1:0]        i_queue_id;
    logic signed [DW-1:0] i_push_value;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic signed [DW-1:0] o_pop_value;

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;
    int sent;
    int idle_pct;

    logic [DW-1:0] corner_values [0:15] = '{
        32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
        32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001, 32'hfffe_fffe,
        32'h8000_0001, 32'h7fff_fffe, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
        32'h1234_5678, 32'hedcb_a987, 32'h00ff_ff00, 32'hff00_00ff
    };

    always #2 i_clk = ~i_clk;

    shared_buffer_multi_queue_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_queue_id   (i_queue_id),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value)
    );

    sbmq_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_queue_id   (i_queue_id),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .full_hits    (full_hits),
        .empty_hits   (empty_hits)
    );

    // Hold one request on the ports until the block takes it; idle the
    // sender at random cycle by cycle.
    task automatic issue_request(input logic cmd, input logic [IW-1:0] qid,
                                 input logic [DW-1:0] value);
        logic taken;
        taken        = 1'b0;
        i_command    <= cmd;
        i_queue_id   <= qid;
        i_push_value <= value;
        while (!taken) begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
            taken = start && !busy;
        end
        sent++;
    endtask

    // Vary the push share in bursts so the store fills and drains repeatedly.
    task automatic run_random(input int count);
        int            push_pct;
        int            focus_q;
        logic          cmd;
        logic [IW-1:0] qid;
        logic [DW-1:0] value;
        push_pct = 50;
        focus_q  = -1;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
                focus_q = ($urandom_range(2) == 0) ? int'($urandom_range(QUEUES - 1)) : -1;
            end
            cmd   = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
            qid   = (focus_q >= 0) ? IW'(focus_q) : IW'($urandom_range(3));
            value = ($urandom_range(9) == 0) ? corner_values[$urandom_range(15)] : $urandom;
            issue_request(cmd, qid, value);
        end
    endtask

    initial begin
        sent         = 0;
        idle_pct     = 0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_command    <= CMD_PUSH;
        i_queue_id   <= '0;
        i_push_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every queue starts empty
        for (int q = 0; q < 4; q++) issue_request(CMD_POP, IW'(q), $urandom);
        // fill the whole store, interleaving queues
        for (int k = 0; k < SLOTS; k++) issue_request(CMD_PUSH, IW'(k % 4), corner_values[k]);
        issue_request(CMD_PUSH, IW'(2), 32'hdead_beef);
        // drain queue 3 completely, then reuse it
        for (int k = 0; k < 4; k++) issue_request(CMD_POP, IW'(3), $urandom);
        issue_request(CMD_PUSH, IW'(3), 32'h8000_0000);

        idle_pct = 20;
        run_random(475);
        idle_pct = 65;
        run_random(475);
        idle_pct = 0;
        run_random(475);
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d requests over three sender idle profiles, %0d results checked.",
                 sent, checked);
        $display("Refusals predicted: %0d with the store full, %0d with the queue empty.",
                 full_hits, empty_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #100us;
        $display("Timeout with %0d results still outstanding.", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sbmq_pkg.sv
sv/sbmq_link_store.sv
sv/sbmq_data_store.sv
sv/sbmq_seq.sv
sv/shared_buffer_multi_queue_unit.sv
sv/sbmq_checker.sv
test/sbmq_result_checker.sv
test/tb_shared_buffer_multi_queue_unit.sv
